/* design/z80s_pkg.sv */
`timescale 1ns / 1ps
// Shared types for the Z80 subset executor: instruction classes and the
// decoded entry that travels from the decoder through the queue to the
// execute stage. No dependencies.
package z80s_pkg;

  typedef enum logic [3:0] {
    KIND_NOP    = 4'd0,
    KIND_LD16   = 4'd1,
    KIND_ADDHL  = 4'd2,
    KIND_INCDEC = 4'd3,
    KIND_LDRN   = 4'd4,
    KIND_LDRR   = 4'd5,
    KIND_HALT   = 4'd6,
    KIND_ALUR   = 4'd7,
    KIND_ALUN   = 4'd8,
    KIND_JPCC   = 4'd9,
    KIND_JP     = 4'd10,
    KIND_OUT    = 4'd11,
    KIND_BAD    = 4'd12
  } kind_t;

  // Register codes as the opcode encodes them
  localparam logic [2:0] REG_HL_MEM = 3'd6;
  localparam logic [2:0] REG_A      = 3'd7;

  // ALU operation codes
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_SBC = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_OR  = 3'd6;
  localparam logic [2:0] ALU_CP  = 3'd7;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
  } dec_t;

endpackage

/* design/z80s_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the instruction input and the result
// output. No dependencies.
interface z80s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] imm_low;
  logic [7:0] imm_high;

  modport source (output valid, output opcode, output imm_low, output imm_high, input ready);
  modport sink   (input valid, input opcode, input imm_low, input imm_high, output ready);
endinterface

interface z80s_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        out_valid;
  logic        out_port;
  logic [7:0]  out_value;
  logic        halted;
  logic        unsupported;
  logic [7:0]  acc_now;
  logic [7:0]  flags_now;

  modport source (output valid, output next_pc, output out_valid, output out_port,
                  output out_value, output halted, output unsupported, output acc_now,
                  output flags_now, input ready);
  modport sink   (input valid, input next_pc, input out_valid, input out_port,
                  input out_value, input halted, input unsupported, input acc_now,
                  input flags_now, output ready);
endinterface

/* design/z80s_decode.sv */
`timescale 1ns / 1ps
// Front end: classifies each incoming instruction into a decoded entry.
// Depends on z80s_pkg and z80s_in_if.
module z80s_decode (
  z80s_in_if.sink         in_ch,
  output logic            push,
  output z80s_pkg::dec_t  push_data,
  input  logic            q_full
);

  logic [1:0] x;
  logic [2:0] y;
  logic [2:0] z;
  logic [1:0] p;
  logic       q;
  z80s_pkg::kind_t kind;

  assign x = in_ch.opcode[7:6];
  assign y = in_ch.opcode[5:3];
  assign z = in_ch.opcode[2:0];
  assign p = in_ch.opcode[5:4];
  assign q = in_ch.opcode[3];

  always_comb begin
    kind = z80s_pkg::KIND_BAD;
    case (x)
      2'd0: begin
        if (z == 3'd0 && y == 3'd0)                                 kind = z80s_pkg::KIND_NOP;
        else if (z == 3'd1 && !q)                                   kind = z80s_pkg::KIND_LD16;
        else if (z == 3'd1)                                         kind = z80s_pkg::KIND_ADDHL;
        else if ((z == 3'd4 || z == 3'd5) && y != z80s_pkg::REG_HL_MEM)
          kind = z80s_pkg::KIND_INCDEC;
        else if (z == 3'd6 && y != z80s_pkg::REG_HL_MEM)             kind = z80s_pkg::KIND_LDRN;
      end
      2'd1: begin
        if (y == z80s_pkg::REG_HL_MEM && z == z80s_pkg::REG_HL_MEM)  kind = z80s_pkg::KIND_HALT;
        else if (y != z80s_pkg::REG_HL_MEM && z != z80s_pkg::REG_HL_MEM)
          kind = z80s_pkg::KIND_LDRR;
      end
      2'd2: begin
        if (z != z80s_pkg::REG_HL_MEM)                              kind = z80s_pkg::KIND_ALUR;
      end
      default: begin
        if (z == 3'd2)                                              kind = z80s_pkg::KIND_JPCC;
        else if (z == 3'd3 && y == 3'd0)                            kind = z80s_pkg::KIND_JP;
        else if (z == 3'd3 && y == 3'd2 && in_ch.imm_low[7:1] == 7'd0)
          kind = z80s_pkg::KIND_OUT;
        else if (z == 3'd6)                                         kind = z80s_pkg::KIND_ALUN;
      end
    endcase
  end

  assign in_ch.ready        = !q_full;
  assign push               = in_ch.valid && !q_full;
  assign push_data.kind     = kind;
  assign push_data.y        = y;
  assign push_data.z        = z;
  assign push_data.p        = p;
  assign push_data.imm_low  = in_ch.imm_low;
  assign push_data.imm_high = in_ch.imm_high;

endmodule

/* design/z80s_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of decoded instructions between decoder and execute stage.
// Depends on z80s_pkg.
module z80s_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  z80s_pkg::dec_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_vld,
  output z80s_pkg::dec_t head
);

  z80s_pkg::dec_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign head_vld = (count_r != 2'd0);
  assign head     = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

endmodule

/* design/z80s_exec.sv */
`timescale 1ns / 1ps
// Back end: holds the architectural registers, executes one decoded instruction per
// cycle unless stalled, registers the result. Depends on z80s_pkg, z80s_out_if.
module z80s_exec (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_vld,
  input  z80s_pkg::dec_t  head,
  output logic            pop,
  z80s_out_if.source      out_ch
);

  logic [7:0]  acc_r, acc_nxt, flag_r, flag_nxt;
  logic [7:0]  b_r, b_nxt, c_r, c_nxt, d_r, d_nxt, e_r, e_nxt, h_r, h_nxt, l_r, l_nxt;
  logic [15:0] sp_r, sp_nxt, pc_r, pc_nxt;
  logic        halt_r, halt_nxt;

  logic        ovld_r;
  logic [15:0] o_pc_r;
  logic        o_ov_r, o_port_r, o_halt_r, o_bad_r;
  logic [7:0]  o_val_r, o_acc_r, o_flag_r;

  logic [7:0]  src_val, dst_val, alu_o, alu_n, alu_v, id_v;
  logic [15:0] pair_val, hl, nn, hl_sum;
  logic        alu_sub, cond_ok, cy;
  logic        wr8_en, wr16_en, flag_en;
  logic [2:0]  wr8_code;
  logic [1:0]  wr16_pair;
  logic [7:0]  wr8_data, flag_data;
  logic [15:0] wr16_data;
  logic        bad, ov;

  function automatic logic [7:0] mk_flags(input logic [7:0] f, input logic [7:0] o,
                                          input logic [7:0] v, input logic sub);
    logic c, hc;
    if (sub) begin
      c  = (v > o);
      hc = (v[3:0] > o[3:0]);
    end else begin
      c  = (v < o);
      hc = (v[3:0] < o[3:0]);
    end
    return {v[7], (v == 8'd0), f[5], hc, f[3], 1'b0, sub, c};
  endfunction

  assign hl     = {h_r, l_r};
  assign nn     = {head.imm_high, head.imm_low};
  assign hl_sum = hl + pair_val;
  assign cy     = flag_r[0];
  assign pop    = head_vld && (!ovld_r || out_ch.ready);

  // Operand reads
  always_comb begin
    case (head.z)
      3'd0:    src_val = b_r;
      3'd1:    src_val = c_r;
      3'd2:    src_val = d_r;
      3'd3:    src_val = e_r;
      3'd4:    src_val = h_r;
      3'd5:    src_val = l_r;
      3'd7:    src_val = acc_r;
      default: src_val = 8'd0;
    endcase
    case (head.y)
      3'd0:    dst_val = b_r;
      3'd1:    dst_val = c_r;
      3'd2:    dst_val = d_r;
      3'd3:    dst_val = e_r;
      3'd4:    dst_val = h_r;
      3'd5:    dst_val = l_r;
      3'd7:    dst_val = acc_r;
      default: dst_val = 8'd0;
    endcase
    case (head.p)
      2'd0:    pair_val = {b_r, c_r};
      2'd1:    pair_val = {d_r, e_r};
      2'd2:    pair_val = hl;
      default: pair_val = sp_r;
    endcase
    case (head.y)
      3'd0:    cond_ok = !flag_r[6];
      3'd1:    cond_ok = flag_r[6];
      3'd2:    cond_ok = !flag_r[0];
      3'd3:    cond_ok = flag_r[0];
      3'd4:    cond_ok = !flag_r[2];
      3'd5:    cond_ok = flag_r[2];
      3'd6:    cond_ok = !flag_r[7];
      default: cond_ok = flag_r[7];
    endcase
  end

  // 8-bit ALU
  assign alu_o = acc_r;
  assign alu_n = (head.kind == z80s_pkg::KIND_ALUN) ? head.imm_low : src_val;
  always_comb begin
    alu_sub = 1'b0;
    case (head.y)
      z80s_pkg::ALU_ADD: alu_v = alu_o + alu_n;
      z80s_pkg::ALU_ADC: alu_v = alu_o + alu_n + {7'd0, cy};
      z80s_pkg::ALU_SUB: begin alu_v = alu_o - alu_n; alu_sub = 1'b1; end
      z80s_pkg::ALU_SBC: begin alu_v = alu_o - alu_n - {7'd0, cy}; alu_sub = 1'b1; end
      z80s_pkg::ALU_AND: alu_v = alu_o & alu_n;
      z80s_pkg::ALU_XOR: alu_v = alu_o ^ alu_n;
      z80s_pkg::ALU_OR:  alu_v = alu_o | alu_n;
      default:           begin alu_v = alu_o - alu_n; alu_sub = 1'b1; end
    endcase
  end

  // INC when z is 4, DEC when z is 5
  assign id_v = head.z[0] ? dst_val - 8'd1 : dst_val + 8'd1;

  // Execute: work out writes, next PC and the result fields
  always_comb begin
    wr8_en    = 1'b0;
    wr8_code  = head.y;
    wr8_data  = head.imm_low;
    wr16_en   = 1'b0;
    wr16_pair = head.p;
    wr16_data = nn;
    flag_en   = 1'b0;
    flag_data = mk_flags(flag_r, alu_o, alu_v, alu_sub);
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    bad       = 1'b0;
    ov        = 1'b0;
    if (!halt_r) begin
      case (head.kind)
        z80s_pkg::KIND_NOP:  pc_nxt = pc_r + 16'd1;
        z80s_pkg::KIND_LD16: begin
          wr16_en = 1'b1;
          pc_nxt  = pc_r + 16'd3;
        end
        z80s_pkg::KIND_ADDHL: begin
          wr16_en   = 1'b1;
          wr16_pair = 2'd2;
          wr16_data = hl_sum;
          pc_nxt    = pc_r + 16'd1;
        end
        z80s_pkg::KIND_INCDEC: begin
          wr8_en    = 1'b1;
          wr8_data  = id_v;
          flag_en   = 1'b1;
          flag_data = mk_flags(flag_r, dst_val, id_v, head.z[0]);
          pc_nxt    = pc_r + 16'd1;
        end
        z80s_pkg::KIND_LDRN: begin
          wr8_en = 1'b1;
          pc_nxt = pc_r + 16'd2;
        end
        z80s_pkg::KIND_LDRR: begin
          wr8_en   = 1'b1;
          wr8_data = src_val;
          pc_nxt   = pc_r + 16'd1;
        end
        z80s_pkg::KIND_HALT: halt_nxt = 1'b1;
        z80s_pkg::KIND_ALUR, z80s_pkg::KIND_ALUN: begin
          wr8_en   = (head.y != z80s_pkg::ALU_CP);
          wr8_code = z80s_pkg::REG_A;
          wr8_data = alu_v;
          flag_en  = 1'b1;
          pc_nxt   = (head.kind == z80s_pkg::KIND_ALUN) ? pc_r + 16'd2 : pc_r + 16'd1;
        end
        z80s_pkg::KIND_JPCC: pc_nxt = cond_ok ? nn : pc_r + 16'd3;
        z80s_pkg::KIND_JP:   pc_nxt = nn;
        z80s_pkg::KIND_OUT: begin
          ov     = 1'b1;
          pc_nxt = pc_r + 16'd2;
        end
        default: bad = 1'b1;
      endcase
    end
  end

  // Apply the register writes
  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    e_nxt    = e_r;
    h_nxt    = h_r;
    l_nxt    = l_r;
    sp_nxt   = sp_r;
    flag_nxt = flag_en ? flag_data : flag_r;
    if (wr8_en) begin
      case (wr8_code)
        3'd0:    b_nxt   = wr8_data;
        3'd1:    c_nxt   = wr8_data;
        3'd2:    d_nxt   = wr8_data;
        3'd3:    e_nxt   = wr8_data;
        3'd4:    h_nxt   = wr8_data;
        3'd5:    l_nxt   = wr8_data;
        3'd7:    acc_nxt = wr8_data;
        default: acc_nxt = acc_r;
      endcase
    end
    if (wr16_en) begin
      case (wr16_pair)
        2'd0:    begin b_nxt = wr16_data[15:8]; c_nxt = wr16_data[7:0]; end
        2'd1:    begin d_nxt = wr16_data[15:8]; e_nxt = wr16_data[7:0]; end
        2'd2:    begin h_nxt = wr16_data[15:8]; l_nxt = wr16_data[7:0]; end
        default: sp_nxt = wr16_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 8'd0;
      flag_r <= 8'd0;
      b_r    <= 8'd0;
      c_r    <= 8'd0;
      d_r    <= 8'd0;
      e_r    <= 8'd0;
      h_r    <= 8'd0;
      l_r    <= 8'd0;
      sp_r   <= 16'd0;
      pc_r   <= 16'd0;
      halt_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (pop) begin
        acc_r  <= acc_nxt;
        flag_r <= flag_nxt;
        b_r    <= b_nxt;
        c_r    <= c_nxt;
        d_r    <= d_nxt;
        e_r    <= e_nxt;
        h_r    <= h_nxt;
        l_r    <= l_nxt;
        sp_r   <= sp_nxt;
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
        ovld_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  // Result register; payload needs no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      o_pc_r   <= pc_nxt;
      o_ov_r   <= ov;
      o_port_r <= ov & head.imm_low[0];
      o_val_r  <= ov ? acc_r : 8'd0;
      o_halt_r <= halt_nxt;
      o_bad_r  <= bad;
      o_acc_r  <= acc_nxt;
      o_flag_r <= flag_nxt;
    end
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.next_pc     = o_pc_r;
  assign out_ch.out_valid   = o_ov_r;
  assign out_ch.out_port    = o_port_r;
  assign out_ch.out_value   = o_val_r;
  assign out_ch.halted      = o_halt_r;
  assign out_ch.unsupported = o_bad_r;
  assign out_ch.acc_now     = o_acc_r;
  assign out_ch.flags_now   = o_flag_r;

endmodule

/* design/z80_subset_instruction_execute.sv */
`timescale 1ns / 1ps
// Z80 subset instruction executor, top level.
// Depends on z80s_pkg, z80s_if, z80s_decode, z80s_queue and z80s_exec.
//
// Usage:
//   in_ch  - valid/ready channel carrying one instruction per transfer: the
//            opcode and the two bytes that follow it, fetched by the caller.
//   out_ch - valid/ready channel giving exactly one result per instruction:
//            next PC, port write, halt mark, unsupported mark, A and F.
// Path: an instruction transfer is decoded and written into a queue entry; the
//   execute stage then executes it and registers the result in its result
//   register. Throughput is one instruction per cycle while out_ch.ready stays
//   high; the execute stage updates all registers together, so a dependent
//   instruction may follow directly.
// Reset (rst_n low, synchronous): A, F, B-L, SP, PC and the halt mark clear,
//   the queue empties and no result is pending.
// Stall: when the receiver holds out_ch.ready low the result register holds
//   its value, the two-entry queue fills and in_ch.ready drops once it is full.
// Once HALT has executed, further instructions are still taken but only
//   report the frozen state until reset.
module z80_subset_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  z80s_in_if.sink     in_ch,
  z80s_out_if.source  out_ch
);

  logic           push;
  logic           q_full;
  logic           pop;
  logic           head_vld;
  z80s_pkg::dec_t push_data;
  z80s_pkg::dec_t head;

  // Front: classify the incoming instruction
  z80s_decode u_decode (
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Decouple front from back so each may stall on its own
  z80s_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_vld  (head_vld),
    .head      (head)
  );

  // Back: execute against the register state and hold the result
  z80s_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
